>>> design/evr_pkg.sv
`timescale 1ns / 1ps

package evr_pkg;

  localparam int DEF_RECORD_DEPTH   = 32768;
  localparam int DEF_CHUNK_LENGTH   = 256;
  localparam int DEF_PREROLL_LENGTH = 512;

  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_READ   = 3'd1;
  localparam logic [2:0] CMD_LISTEN = 3'd2;
  localparam logic [2:0] CMD_RECORD = 3'd3;
  localparam logic [2:0] CMD_STOP   = 3'd4;

  localparam logic [2:0] REG_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_ONSET      = 3'd1;
  localparam logic [2:0] REG_HANGOVER   = 3'd2;
  localparam logic [2:0] REG_MIN_SPEECH = 3'd3;
  localparam logic [2:0] REG_MAX_SPEECH = 3'd4;

  localparam logic [14:0] RST_THRESHOLD  = 15'd1500;
  localparam logic [7:0]  RST_ONSET      = 8'd3;
  localparam logic [7:0]  RST_HANGOVER   = 8'd20;
  localparam logic [15:0] RST_MIN_SPEECH = 16'd10;
  localparam logic [15:0] RST_MAX_SPEECH = 16'd500;

  localparam logic [15:0] LEVEL_FLOOR = 16'd200;
  localparam logic [15:0] LEVEL_FULL  = 16'd15000;
  localparam logic [6:0]  LEVEL_MAX   = 7'd100;
  // floor(x / 150) for x < 15000
  localparam logic [15:0] RECIP_MULT  = 16'd55925;
  localparam int          RECIP_SHIFT = 23;

  localparam int ROOT_STEPS = 16;

  typedef struct packed {
    logic capture;
    logic push;
    logic read;
    logic clear_chunk;
    logic clear_stored;
    logic clear_fill;
    logic root_start;
    logic update_rms;
    logic drop_chunk;
    logic fill_adv;
    logic copy_go;
    logic copy_pre;
    logic out_load;
    logic out_speak;
    logic out_record;
    logic out_ended;
    logic out_dropped;
  } evr_cmd_t;

  typedef struct packed {
    logic chunk_last;
    logic root_busy;
    logic voiced;
    logic full;
    logic copy_busy;
    logic out_free;
  } evr_stat_t;

endpackage

>>> design/evr_intf.sv
`timescale 1ns / 1ps

interface evr_item_if;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic signed [15:0] sample;
  logic [14:0]       read_address;

  modport source (output valid, command, sample, read_address, input ready);
  modport sink (input valid, command, sample, read_address, output ready);
endinterface

interface evr_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] read_data;
  logic               is_speaking;
  logic               is_recording;
  logic               speech_ended;
  logic               noise_dropped;
  logic [15:0]        stored_count;
  logic [15:0]        chunk_rms;
  logic [6:0]         level_percent;

  modport source (output valid, read_data, is_speaking, is_recording, speech_ended,
                  noise_dropped, stored_count, chunk_rms, level_percent, input ready);
  modport sink (input valid, read_data, is_speaking, is_recording, speech_ended,
                noise_dropped, stored_count, chunk_rms, level_percent, output ready);
endinterface

>>> design/evr_root.sv
`timescale 1ns / 1ps

module evr_root #(
  parameter int CHUNK_LENGTH = evr_pkg::DEF_CHUNK_LENGTH,
  localparam int SUM_W = 31 + $clog2(CHUNK_LENGTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  output logic             busy,
  output logic [15:0]      rms
);

  // CHUNK_LENGTH is a power of two: take the mean with a right shift
  localparam int KW = $clog2(CHUNK_LENGTH);
  localparam int SW = $clog2(evr_pkg::ROOT_STEPS + 1);
  localparam logic PH_IDLE = 1'b0;
  localparam logic PH_SQRT = 1'b1;

  logic             phase;
  logic [SW-1:0]    steps;
  logic [SUM_W-1:0] quo;
  logic [17:0]      srem;
  logic [15:0]      root;

  logic [19:0]   sh;
  logic [19:0]   trial;

  assign sh    = {srem, quo[31:30]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      steps <= '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (start) begin
            phase <= PH_SQRT;
            steps <= SW'(evr_pkg::ROOT_STEPS);
          end
        end
        PH_SQRT: begin
          steps <= steps - 1'b1;
          if (steps == SW'(1)) begin
            phase <= PH_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase == PH_IDLE && start) begin
      quo  <= dividend >> KW;
      srem <= '0;
      root <= '0;
    end else if (phase == PH_SQRT) begin
      quo <= quo << 2;
      if (sh >= trial) begin
        srem <= 18'(sh - trial);
        root <= {root[14:0], 1'b1};
      end else begin
        srem <= sh[17:0];
        root <= {root[14:0], 1'b0};
      end
    end
  end

  assign busy = phase != PH_IDLE;
  assign rms  = root;

endmodule

>>> design/evr_dp.sv
`timescale 1ns / 1ps

module evr_dp #(
  parameter int RECORD_DEPTH   = evr_pkg::DEF_RECORD_DEPTH,
  parameter int CHUNK_LENGTH   = evr_pkg::DEF_CHUNK_LENGTH,
  parameter int PREROLL_LENGTH = evr_pkg::DEF_PREROLL_LENGTH
) (
  input  logic                clk,
  input  logic                rst,
  input  evr_pkg::evr_cmd_t   cmd,
  input  logic signed [15:0]  sample,
  input  logic [14:0]         read_address,
  input  logic [14:0]         energy_threshold,
  output evr_pkg::evr_stat_t  stat,
  evr_result_if.source        result
);

  localparam int RING  = PREROLL_LENGTH + CHUNK_LENGTH;
  localparam int RPW   = $clog2(RING);
  localparam int AW    = $clog2(RECORD_DEPTH);
  localparam int CW    = $clog2(RECORD_DEPTH + 1);
  localparam int CMPW  = (CW > 15) ? CW : 15;
  localparam int KW    = $clog2(CHUNK_LENGTH);
  localparam int FW    = $clog2(PREROLL_LENGTH + 2);
  localparam int LW    = $clog2(RING + 1);
  localparam int SUM_W = 31 + $clog2(CHUNK_LENGTH);

  logic signed [15:0] ring_mem [RING];
  logic signed [15:0] record_mem [RECORD_DEPTH];

  logic signed [15:0] sample_q;
  logic [14:0]        addr_q;
  logic [RPW-1:0]     wp;
  logic [KW-1:0]      cnt;
  logic [SUM_W-1:0]   sum;
  logic [CW-1:0]      stored;
  logic [FW-1:0]      fill;
  logic [15:0]        last_rms;
  logic [RPW-1:0]     cp_ptr;
  logic [LW-1:0]      cp_left;
  logic               wr_pend;
  logic signed [15:0] ring_q;
  logic signed [15:0] mem_q;
  logic               rd_ok;

  logic               out_valid;
  logic signed [15:0] out_data;
  logic               out_speak;
  logic               out_record;
  logic               out_ended;
  logic               out_dropped;
  logic [15:0]        out_count;
  logic [15:0]        out_rms;
  logic [6:0]         out_level;

  logic signed [31:0] sq;
  logic [SUM_W-1:0]   sum_add;
  logic [RPW-1:0]     wp_inc;
  logic [RPW-1:0]     cp_inc;
  logic [RPW:0]       wp_x;
  logic [RPW:0]       cs_x;
  logic [RPW:0]       fill_x;
  logic [RPW:0]       ps_x;
  logic [LW-1:0]      fill_sum;
  logic [FW-1:0]      fill_adv;
  logic               stored_lt;
  logic [CMPW-1:0]    addr_ext;
  logic [CMPW-1:0]    stored_ext;
  logic               in_range;
  logic               root_busy;
  logic [15:0]        root_rms;
  logic [29:0]        prod;
  logic [6:0]         level;

  evr_root #(.CHUNK_LENGTH(CHUNK_LENGTH)) u_root (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.root_start),
    .dividend(sum_add),
    .busy    (root_busy),
    .rms     (root_rms)
  );

  assign sq       = sample_q * sample_q;
  assign sum_add  = sum + SUM_W'($unsigned(sq));
  assign wp_inc   = (wp == RPW'(RING - 1)) ? '0 : wp + 1'b1;
  assign cp_inc   = (cp_ptr == RPW'(RING - 1)) ? '0 : cp_ptr + 1'b1;
  assign wp_x     = {1'b0, wp};
  assign cs_x     = (wp_x >= (RPW+1)'(CHUNK_LENGTH)) ? wp_x - (RPW+1)'(CHUNK_LENGTH)
                                                      : wp_x + (RPW+1)'(PREROLL_LENGTH);
  assign fill_x   = (RPW+1)'(fill);
  assign ps_x     = (cs_x >= fill_x) ? cs_x - fill_x : cs_x + (RPW+1)'(RING) - fill_x;
  assign fill_sum = LW'(fill) + LW'(CHUNK_LENGTH);
  assign fill_adv = (fill_sum > LW'(PREROLL_LENGTH)) ? FW'(PREROLL_LENGTH) : FW'(fill_sum);
  assign stored_lt  = stored < CW'(RECORD_DEPTH);
  assign addr_ext   = CMPW'(addr_q);
  assign stored_ext = CMPW'(stored);
  assign in_range   = addr_ext < stored_ext;

  assign prod = 30'(last_rms[13:0]) * 30'(evr_pkg::RECIP_MULT);
  always_comb begin
    priority if (last_rms < evr_pkg::LEVEL_FLOOR) begin
      level = '0;
    end else if (last_rms >= evr_pkg::LEVEL_FULL) begin
      level = evr_pkg::LEVEL_MAX;
    end else begin
      level = 7'(prod >> evr_pkg::RECIP_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_q <= sample;
      addr_q   <= read_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp        <= '0;
      cnt       <= '0;
      sum       <= '0;
      stored    <= '0;
      fill      <= '0;
      last_rms  <= '0;
      cp_ptr    <= '0;
      cp_left   <= '0;
      wr_pend   <= 1'b0;
      rd_ok     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.capture) begin
        rd_ok <= 1'b0;
      end
      if (cmd.read) begin
        rd_ok <= in_range;
      end
      if (cmd.push) begin
        wp <= wp_inc;
        if (stat.chunk_last) begin
          cnt <= '0;
          sum <= '0;
        end else begin
          cnt <= cnt + 1'b1;
          sum <= sum_add;
        end
      end
      if (cmd.clear_chunk) begin
        cnt <= '0;
        sum <= '0;
      end
      if (cmd.clear_stored) begin
        stored <= '0;
      end
      if (cmd.clear_fill) begin
        fill <= '0;
      end
      if (cmd.fill_adv) begin
        fill <= fill_adv;
      end
      if (cmd.update_rms) begin
        last_rms <= root_rms;
      end
      if (cmd.drop_chunk) begin
        wp <= cs_x[RPW-1:0];
      end
      if (cmd.copy_go) begin
        cp_ptr  <= cmd.copy_pre ? ps_x[RPW-1:0] : cs_x[RPW-1:0];
        cp_left <= cmd.copy_pre ? LW'(fill_sum) : LW'(CHUNK_LENGTH);
      end else if (cp_left != '0) begin
        cp_ptr  <= cp_inc;
        cp_left <= cp_left - 1'b1;
      end
      wr_pend <= cp_left != '0;
      if (wr_pend && stored_lt) begin
        stored <= stored + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring_mem[wp] <= sample_q;
    end
    if (cp_left != '0) begin
      ring_q <= ring_mem[cp_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_pend && stored_lt) begin
      record_mem[stored[AW-1:0]] <= ring_q;
    end
    if (cmd.read) begin
      mem_q <= record_mem[addr_ext[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data    <= rd_ok ? mem_q : '0;
      out_speak   <= cmd.out_speak;
      out_record  <= cmd.out_record;
      out_ended   <= cmd.out_ended;
      out_dropped <= cmd.out_dropped;
      out_count   <= 16'(stored);
      out_rms     <= last_rms;
      out_level   <= level;
    end
  end

  assign stat.chunk_last = cnt == KW'(CHUNK_LENGTH - 1);
  assign stat.root_busy  = root_busy;
  assign stat.voiced     = root_rms > {1'b0, energy_threshold};
  assign stat.full       = !stored_lt;
  assign stat.copy_busy  = (cp_left != '0) || wr_pend;
  assign stat.out_free   = !out_valid || result.ready;

  assign result.valid         = out_valid;
  assign result.read_data     = out_data;
  assign result.is_speaking   = out_speak;
  assign result.is_recording  = out_record;
  assign result.speech_ended  = out_ended;
  assign result.noise_dropped = out_dropped;
  assign result.stored_count  = out_count;
  assign result.chunk_rms     = out_rms;
  assign result.level_percent = out_level;

  a_stored_bound: assert property (@(posedge clk) disable iff (rst)
    stored <= CW'(RECORD_DEPTH)) else $error("stored count past depth");
  a_copy_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.copy_go |-> !stat.copy_busy) else $error("copy started while busy");
  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    wp_x < (RPW+1)'(RING)) else $error("ring pointer out of range");

endmodule

>>> design/evr_ctrl.sv
`timescale 1ns / 1ps

module evr_ctrl (
  input  logic               clk,
  input  logic               rst,
  evr_item_if.sink           item,
  input  logic [7:0]         onset_chunks,
  input  logic [7:0]         hangover_chunks,
  input  logic [15:0]        min_speech_chunks,
  input  logic [15:0]        max_speech_chunks,
  input  evr_pkg::evr_stat_t stat,
  output evr_pkg::evr_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_ROOT   = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_COPY   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]  state, state_next;
  logic [2:0]  op;
  logic        listen, listen_next;
  logic        record, record_next;
  logic        speak, speak_next;
  logic [7:0]  voiced_run, voiced_run_next;
  logic [7:0]  quiet_run, quiet_run_next;
  logic [15:0] speech_length, speech_length_next;
  logic        ended, ended_next;
  logic        dropped, dropped_next;
  logic        accept;

  logic [7:0]  vr_inc;
  logic [7:0]  vr_new;
  logic [7:0]  qr_inc;
  logic [15:0] len_inc;
  logic        finish;

  assign item.ready = state == S_IDLE;
  assign accept     = item.valid && item.ready;
  assign vr_inc     = (voiced_run == 8'hFF) ? voiced_run : voiced_run + 1'b1;
  assign vr_new     = stat.voiced ? vr_inc : '0;
  assign qr_inc     = (quiet_run == 8'hFF) ? quiet_run : quiet_run + 1'b1;
  assign len_inc    = (speech_length == 16'hFFFF) ? speech_length : speech_length + 1'b1;

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= item.command;
    end
  end

  always_comb begin
    state_next         = state;
    listen_next        = listen;
    record_next        = record;
    speak_next         = speak;
    voiced_run_next    = voiced_run;
    quiet_run_next     = quiet_run;
    speech_length_next = speech_length;
    ended_next         = ended;
    dropped_next       = dropped;
    finish             = 1'b0;
    cmd                = '0;
    cmd.capture        = accept;
    cmd.out_speak      = speak;
    cmd.out_record     = record;
    cmd.out_ended      = ended;
    cmd.out_dropped    = dropped;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next   = S_EXEC;
          ended_next   = 1'b0;
          dropped_next = 1'b0;
        end
      end
      S_EXEC: begin
        state_next = S_RESP;
        unique case (op)
          evr_pkg::CMD_PUSH: begin
            if (listen || record) begin
              cmd.push = 1'b1;
              if (stat.chunk_last) begin
                cmd.root_start = 1'b1;
                state_next     = S_ROOT;
              end
            end
          end
          evr_pkg::CMD_READ: cmd.read = 1'b1;
          evr_pkg::CMD_LISTEN: begin
            cmd.clear_stored   = 1'b1;
            cmd.clear_fill     = 1'b1;
            cmd.clear_chunk    = 1'b1;
            listen_next        = 1'b1;
            record_next        = 1'b0;
            speak_next         = 1'b0;
            voiced_run_next    = '0;
            quiet_run_next     = '0;
            speech_length_next = '0;
          end
          evr_pkg::CMD_RECORD: begin
            cmd.clear_stored = 1'b1;
            cmd.clear_chunk  = 1'b1;
            listen_next      = 1'b0;
            record_next      = 1'b1;
            speak_next       = 1'b0;
          end
          evr_pkg::CMD_STOP: begin
            cmd.clear_chunk = 1'b1;
            listen_next     = 1'b0;
            record_next     = 1'b0;
            speak_next      = 1'b0;
          end
          default: ;
        endcase
      end
      S_ROOT: begin
        if (!stat.root_busy) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_RESP;
        if (record && stat.full) begin
          record_next    = 1'b0;
          speak_next     = 1'b0;
          cmd.drop_chunk = 1'b1;
          ended_next     = 1'b1;
        end else begin
          if (listen) begin
            cmd.update_rms  = 1'b1;
            voiced_run_next = vr_new;
            if (stat.voiced) begin
              quiet_run_next = '0;
              if (speak) begin
                speech_length_next = len_inc;
                if (len_inc >= max_speech_chunks) begin
                  finish     = 1'b1;
                  ended_next = 1'b1;
                end
              end
            end else if (speak) begin
              quiet_run_next = qr_inc;
              if (qr_inc >= hangover_chunks) begin
                finish = 1'b1;
                if (speech_length >= min_speech_chunks) begin
                  ended_next = 1'b1;
                end else begin
                  dropped_next     = 1'b1;
                  cmd.clear_stored = 1'b1;
                end
              end
            end
            if (finish) begin
              record_next    = 1'b0;
              speak_next     = 1'b0;
              cmd.drop_chunk = 1'b1;
            end else begin
              if (!speak && vr_new >= onset_chunks) begin
                record_next        = 1'b1;
                speak_next         = 1'b1;
                quiet_run_next     = '0;
                speech_length_next = 16'd1;
                cmd.copy_pre       = 1'b1;
              end
              cmd.fill_adv = 1'b1;
            end
          end
          if (!finish && record_next) begin
            cmd.copy_go = 1'b1;
            state_next  = S_COPY;
          end
        end
      end
      S_COPY: begin
        if (!stat.copy_busy) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        cmd.out_load = stat.out_free;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      listen        <= 1'b0;
      record        <= 1'b0;
      speak         <= 1'b0;
      voiced_run    <= '0;
      quiet_run     <= '0;
      speech_length <= '0;
      ended         <= 1'b0;
      dropped       <= 1'b0;
    end else begin
      state         <= state_next;
      listen        <= listen_next;
      record        <= record_next;
      speak         <= speak_next;
      voiced_run    <= voiced_run_next;
      quiet_run     <= quiet_run_next;
      speech_length <= speech_length_next;
      ended         <= ended_next;
      dropped       <= dropped_next;
    end
  end

  a_speak_rec: assert property (@(posedge clk) disable iff (rst)
    speak |-> record) else $error("speaking without recording");
  a_root_state: assert property (@(posedge clk) disable iff (rst)
    stat.root_busy |-> state == S_ROOT) else $error("root unit busy outside wait");
  a_pulse_excl: assert property (@(posedge clk) disable iff (rst)
    !(ended && dropped)) else $error("end and drop pulses together");

endmodule

>>> design/energy_vad_recorder_core.sv
`timescale 1ns / 1ps
// channel  | dir | beat payload
// item     | in  | command, sample, read_address
// result   | out | read_data, flags, pulses, stored_count, chunk_rms, level_percent
// cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// A beat that does not close a chunk passes through the execute and response states; the next beat waits for idle.
// A chunk-closing push adds the root load, 16 root steps, handoff and one decision.
// Storing the chunk adds the ring-to-memory copy of CHUNK_LENGTH samples, plus the held
// pre-roll at speech start.
// Synchronous active-high reset; memories need no clearing.
// A held result stalls only the last step; the next beat is taken once it moves.

module energy_vad_recorder_core #(
  parameter int RECORD_DEPTH   = evr_pkg::DEF_RECORD_DEPTH,
  parameter int CHUNK_LENGTH   = evr_pkg::DEF_CHUNK_LENGTH,
  parameter int PREROLL_LENGTH = evr_pkg::DEF_PREROLL_LENGTH
) (
  input  logic        clk,
  input  logic        rst,
  evr_item_if.sink    item,
  evr_result_if.source result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [14:0] energy_threshold;
  logic [7:0]  onset_chunks;
  logic [7:0]  hangover_chunks;
  logic [15:0] min_speech_chunks;
  logic [15:0] max_speech_chunks;

  evr_pkg::evr_cmd_t  cmd;
  evr_pkg::evr_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_threshold  <= evr_pkg::RST_THRESHOLD;
      onset_chunks      <= evr_pkg::RST_ONSET;
      hangover_chunks   <= evr_pkg::RST_HANGOVER;
      min_speech_chunks <= evr_pkg::RST_MIN_SPEECH;
      max_speech_chunks <= evr_pkg::RST_MAX_SPEECH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        evr_pkg::REG_THRESHOLD:  energy_threshold  <= cfg_data[14:0];
        evr_pkg::REG_ONSET:      onset_chunks      <= cfg_data[7:0];
        evr_pkg::REG_HANGOVER:   hangover_chunks   <= cfg_data[7:0];
        evr_pkg::REG_MIN_SPEECH: min_speech_chunks <= cfg_data;
        evr_pkg::REG_MAX_SPEECH: max_speech_chunks <= cfg_data;
        default: ;
      endcase
    end
  end

  evr_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .item             (item),
    .onset_chunks     (onset_chunks),
    .hangover_chunks  (hangover_chunks),
    .min_speech_chunks(min_speech_chunks),
    .max_speech_chunks(max_speech_chunks),
    .stat             (stat),
    .cmd              (cmd)
  );

  evr_dp #(
    .RECORD_DEPTH  (RECORD_DEPTH),
    .CHUNK_LENGTH  (CHUNK_LENGTH),
    .PREROLL_LENGTH(PREROLL_LENGTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sample          (item.sample),
    .read_address    (item.read_address),
    .energy_threshold(energy_threshold),
    .stat            (stat),
    .result          (result)
  );

endmodule
